// ===== hdl/gcar_pkg.sv =====
// Shared types and constants for the glyph cache age replacement core
`timescale 1ns / 1ps
package gcar_pkg;

    localparam int CP_W       = 16;
    localparam int SLOT_W     = 4;
    localparam int OFFSET_W   = 23;
    localparam int CNT_W      = 32;
    localparam int AGE_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = 1'b1;

    typedef enum logic [1:0] {
        STAT_REJECT    = 2'd0,
        STAT_HIT       = 2'd1,
        STAT_MISS_FILL = 2'd2,
        STAT_MISS_SKIP = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic take_in;
        logic run;
    } t_ctrl_cmd;

endpackage

// ===== hdl/gcar_req_if.sv =====
// Request channel: UTF-8 bytes, byte count and fill flag
`timescale 1ns / 1ps
interface gcar_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] utf8_byte0;
    logic [7:0] utf8_byte1;
    logic [7:0] utf8_byte2;
    logic [2:0] byte_count;
    logic       fill_ok;

    modport source (
        output valid, utf8_byte0, utf8_byte1, utf8_byte2, byte_count, fill_ok,
        input  ready
    );
    modport sink (
        input  valid, utf8_byte0, utf8_byte1, utf8_byte2, byte_count, fill_ok,
        output ready
    );
endinterface

// ===== hdl/gcar_rsp_if.sv =====
// Result channel: lookup status, slot, codepoint, offset and counters
`timescale 1ns / 1ps
interface gcar_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [gcar_pkg::SLOT_W-1:0]     slot;
    logic [gcar_pkg::CP_W-1:0]       codepoint;
    logic [gcar_pkg::OFFSET_W-1:0]   read_offset;
    logic [gcar_pkg::CNT_W-1:0]      hit_total;
    logic [gcar_pkg::CNT_W-1:0]      miss_total;

    modport source (
        output valid, status, slot, codepoint, read_offset, hit_total, miss_total,
        input  ready
    );
    modport sink (
        input  valid, status, slot, codepoint, read_offset, hit_total, miss_total,
        output ready
    );
endinterface

// ===== hdl/gcar_ctrl.sv =====
// Controller state machine: sequences take, lookup and result hand-off
`timescale 1ns / 1ps
module gcar_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output gcar_pkg::t_ctrl_cmd o_cmd
);
    import gcar_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CALC;
            end
            ST_CALC: begin
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                // a new word may enter in the cycle the result leaves
                if (i_out_ready) n_state = i_in_valid ? ST_CALC : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.run     = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_CALC: o_cmd.run = 1'b1;
            ST_HOLD: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
            end
            default: o_in_ready = 1'b0;
        endcase
        o_cmd.take_in = i_in_valid && o_in_ready;
    end

endmodule

// ===== hdl/gcar_datapath.sv =====
// Datapath: UTF-8 decode, tag store, age search and update, counters
`timescale 1ns / 1ps
module gcar_datapath #(
    parameter int CACHE_ENTRIES = 16,
    parameter int GLYPH_BYTES   = 72
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gcar_pkg::t_ctrl_cmd               i_cmd,
    input  logic                              i_cfg_we,
    input  logic [gcar_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcar_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [7:0]                        i_utf8_byte0,
    input  logic [7:0]                        i_utf8_byte1,
    input  logic [7:0]                        i_utf8_byte2,
    input  logic [2:0]                        i_byte_count,
    input  logic                              i_fill_ok,
    output logic [1:0]                        o_status,
    output logic [gcar_pkg::SLOT_W-1:0]       o_slot,
    output logic [gcar_pkg::CP_W-1:0]         o_codepoint,
    output logic [gcar_pkg::OFFSET_W-1:0]     o_read_offset,
    output logic [gcar_pkg::CNT_W-1:0]        o_hit_total,
    output logic [gcar_pkg::CNT_W-1:0]        o_miss_total
);
    import gcar_pkg::*;

    localparam int IW   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int P    = 1 << IW;
    localparam int GB_W = $clog2(GLYPH_BYTES + 1);
    localparam int PW   = CP_W + GB_W;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    // configuration
    logic                  r_enable;
    logic [CFG_DATA_W-1:0] r_glyph_count;

    // request held for the lookup cycle
    logic [CP_W-1:0] r_cp;
    logic            r_ok;
    logic            r_fill;

    // tag store
    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [CACHE_ENTRIES-1:0] n_valid;
    logic [CP_W-1:0]          r_key [CACHE_ENTRIES];
    logic [AGE_W-1:0]         r_age [CACHE_ENTRIES];
    logic [AGE_W-1:0]         n_age [CACHE_ENTRIES];
    logic [CNT_W-1:0]         r_hits;
    logic [CNT_W-1:0]         n_hits;
    logic [CNT_W-1:0]         r_misses;
    logic [CNT_W-1:0]         n_misses;

    // result register
    t_status             r_status;
    logic [SLOT_W-1:0]   r_slot;
    logic [CP_W-1:0]     r_codepoint;
    logic [OFFSET_W-1:0] r_offset;

    logic [CP_W-1:0]          w_cp;
    logic                     w_ok;
    logic [CACHE_ENTRIES-1:0] w_match;
    logic                     w_hit;
    logic [IW-1:0]            w_hit_idx;
    logic                     w_free;
    logic [IW-1:0]            w_free_idx;
    logic [AGE_W-1:0]         w_tree_age [2*P];
    logic [IW-1:0]            w_tree_idx [2*P];
    logic [IW-1:0]            w_victim;
    logic                     w_key_we;
    logic [PW-1:0]            w_prod;
    t_status                  w_status;

    // UTF-8 decode on the incoming word
    always_comb begin
        w_cp = '0;
        unique case (i_byte_count)
            3'd1: w_cp = {8'h00, i_utf8_byte0};
            3'd2: begin
                if ((i_utf8_byte0 & LEAD2_MASK) == LEAD2_TAG &&
                    (i_utf8_byte1 & CONT_MASK) == CONT_TAG) begin
                    w_cp = {5'b0, 5'(i_utf8_byte0 & LEAD2_BITS),
                            6'(i_utf8_byte1 & CONT_BITS)};
                end
            end
            3'd3: begin
                if ((i_utf8_byte0 & LEAD3_MASK) == LEAD3_TAG &&
                    (i_utf8_byte1 & CONT_MASK) == CONT_TAG &&
                    (i_utf8_byte2 & CONT_MASK) == CONT_TAG) begin
                    w_cp = {4'(i_utf8_byte0 & LEAD3_BITS),
                            6'(i_utf8_byte1 & CONT_BITS),
                            6'(i_utf8_byte2 & CONT_BITS)};
                end
            end
            default: w_cp = '0;
        endcase
        w_ok = r_enable && (i_byte_count != 3'd0) &&
               ({1'b0, w_cp} < r_glyph_count);
    end

    // tag compare, first hit and first free entry
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_key[i] == r_cp);
            if (w_match[i]) w_hit_idx = IW'(i);
            if (!r_valid[i]) w_free_idx = IW'(i);
        end
        w_hit  = |w_match;
        w_free = ~&r_valid;
    end

    // oldest entry: a tree of pairwise compares, ties go to the lower index
    always_comb begin
        for (int i = 0; i < P; i++) begin
            w_tree_age[P+i] = (i < CACHE_ENTRIES) ? r_age[i] : '0;
            w_tree_idx[P+i] = IW'(i);
        end
        w_tree_age[0] = '0;
        w_tree_idx[0] = '0;
        for (int k = P - 1; k >= 1; k--) begin
            if (w_tree_age[2*k+1] > w_tree_age[2*k]) begin
                w_tree_age[k] = w_tree_age[2*k+1];
                w_tree_idx[k] = w_tree_idx[2*k+1];
            end else begin
                w_tree_age[k] = w_tree_age[2*k];
                w_tree_idx[k] = w_tree_idx[2*k];
            end
        end
        w_victim = w_free ? w_free_idx : w_tree_idx[1];
    end

    // state update
    always_comb begin
        n_valid  = r_valid;
        n_age    = r_age;
        n_hits   = r_hits;
        n_misses = r_misses;
        w_key_we = 1'b0;
        if (i_cmd.run && r_ok) begin
            if (w_hit) begin
                n_age[w_hit_idx] = '0;
                n_hits = r_hits + 1'b1;
            end else begin
                n_misses = r_misses + 1'b1;
                // full store: age every entry, saturating
                if (!w_free) begin
                    for (int i = 0; i < CACHE_ENTRIES; i++) begin
                        if (r_age[i] != AGE_MAX) n_age[i] = r_age[i] + 1'b1;
                    end
                end
                if (r_fill) begin
                    n_valid[w_victim] = 1'b1;
                    n_age[w_victim]   = '0;
                    w_key_we          = 1'b1;
                end
            end
        end
    end

    assign w_prod = PW'(r_cp) * PW'(GLYPH_BYTES);

    always_comb begin
        priority if (!r_ok) w_status = STAT_REJECT;
        else if (w_hit)     w_status = STAT_HIT;
        else if (r_fill)    w_status = STAT_MISS_FILL;
        else                w_status = STAT_MISS_SKIP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_glyph_count <= '0;
            r_valid       <= '0;
            r_hits        <= '0;
            r_misses      <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++) r_age[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENABLE:      r_enable      <= i_cfg_wdata[0];
                    CFG_GLYPH_COUNT: r_glyph_count <= i_cfg_wdata;
                    default:         r_enable      <= r_enable;
                endcase
            end
            r_valid  <= n_valid;
            r_age    <= n_age;
            r_hits   <= n_hits;
            r_misses <= n_misses;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_cp   <= w_cp;
            r_ok   <= w_ok;
            r_fill <= i_fill_ok;
        end
        if (w_key_we) r_key[w_victim] <= r_cp;
        if (i_cmd.run) begin
            r_status    <= w_status;
            r_slot      <= r_ok ? SLOT_W'(w_hit ? w_hit_idx : w_victim) : '0;
            r_codepoint <= r_cp;
            r_offset    <= r_ok ? OFFSET_W'(w_prod) : '0;
        end
    end

    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_codepoint   = r_codepoint;
    assign o_read_offset = r_offset;
    assign o_hit_total   = r_hits;
    assign o_miss_total  = r_misses;

endmodule

// ===== hdl/glyph_cache_age_replacement_core.sv =====
// Top level of the glyph cache tag store with age-based replacement
//
//  Channel  | Direction | Handshake        | Word
//  ---------+-----------+------------------+---------------------------------------------
//  i_req    | in        | valid / ready    | utf8_byte0..2, byte_count, fill_ok
//  o_rsp    | out       | valid / ready    | status, slot, codepoint, read_offset, totals
//  i_cfg_*  | in        | write enable     | index 0 enable, index 1 glyph_count
//
//  A word is decoded as it is accepted, then the lookup state (ST_CALC)
//  runs the parallel tag compare, the oldest-entry tree and the age update.
//  The result register holds the word; a new request is taken in the cycle it leaves.
//  Reset is synchronous: valid bits, ages, counters and configuration clear at once.
`timescale 1ns / 1ps
module glyph_cache_age_replacement_core #(
    parameter int CACHE_ENTRIES = 16,
    parameter int GLYPH_BYTES   = 72
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gcar_req_if.sink                        i_req,
    gcar_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [gcar_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gcar_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import gcar_pkg::*;

    t_ctrl_cmd w_cmd;
    logic      w_in_ready;
    logic      w_out_valid;

    gcar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    gcar_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .GLYPH_BYTES   (GLYPH_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_utf8_byte0  (i_req.utf8_byte0),
        .i_utf8_byte1  (i_req.utf8_byte1),
        .i_utf8_byte2  (i_req.utf8_byte2),
        .i_byte_count  (i_req.byte_count),
        .i_fill_ok     (i_req.fill_ok),
        .o_status      (o_rsp.status),
        .o_slot        (o_rsp.slot),
        .o_codepoint   (o_rsp.codepoint),
        .o_read_offset (o_rsp.read_offset),
        .o_hit_total   (o_rsp.hit_total),
        .o_miss_total  (o_rsp.miss_total)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

    // a result is only raised for a request that was taken and then passed the lookup state
    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(i_req.valid && i_req.ready, 2))
        else $error("result word without a request two cycles earlier");

    // a pending result is never overrun by a new request
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.ready && o_rsp.valid) |-> o_rsp.ready)
        else $error("request taken while result word is stalled");

    // a rejected request carries no slot and no offset
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == STAT_REJECT) |->
            (o_rsp.slot == '0 && o_rsp.read_offset == '0))
        else $error("rejected word with non-zero slot or offset");

    // totals only move when a lookup cycle has run
    a_totals_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && $past(o_rsp.valid)) |->
            ($stable(o_rsp.hit_total) && $stable(o_rsp.miss_total)))
        else $error("counters moved while a result word was held");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the glyph cache age replacement core
`timescale 1ns / 1ps
module tb_top;
    import gcar_pkg::*;

    localparam int CACHE_ENTRIES = 16;
    localparam int GLYPH_BYTES   = 72;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SHOW_MAX      = 10;

    typedef struct {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [CP_W-1:0]     cp;
        logic [OFFSET_W-1:0] offset;
        logic [CNT_W-1:0]    hits;
        logic [CNT_W-1:0]    misses;
    } t_glyph_rsp;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

    gcar_req_if req_bus ();
    gcar_rsp_if rsp_bus ();

    glyph_cache_age_replacement_core #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .GLYPH_BYTES   (GLYPH_BYTES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the tag store, counters and registers
    bit                    tag_valid [CACHE_ENTRIES];
    logic [CP_W-1:0]       tag_key   [CACHE_ENTRIES];
    logic [AGE_W-1:0]      tag_age   [CACHE_ENTRIES];
    logic [CNT_W-1:0]      hit_cnt;
    logic [CNT_W-1:0]      miss_cnt;
    logic                  cfg_enable;
    logic [CFG_DATA_W-1:0] cfg_glyphs;

    t_glyph_rsp      pending_rsp [$];
    logic [CP_W-1:0] hot_cp [32];
    int              hot_size;
    bit              gaps_on;
    int              err_count   = 0;
    int              cycle_count = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_rsp.size());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        rsp_bus.ready <= !gaps_on || ($urandom_range(99) >= 32);
    end

    function automatic logic [CP_W-1:0] utf8_to_cp(input logic [7:0] b0, input logic [7:0] b1,
                                                   input logic [7:0] b2, input logic [2:0] n);
        logic [CP_W-1:0] cp;
        cp = '0;
        case (n)
            3'd1: cp = {8'h00, b0};
            3'd2: begin
                if ((b0 & 8'hE0) == 8'hC0 && (b1 & 8'hC0) == 8'h80)
                    cp = {5'd0, b0[4:0], b1[5:0]};
            end
            3'd3: begin
                if ((b0 & 8'hF0) == 8'hE0 && (b1 & 8'hC0) == 8'h80 && (b2 & 8'hC0) == 8'h80)
                    cp = {b0[3:0], b1[5:0], b2[5:0]};
            end
            default: cp = '0;
        endcase
        return cp;
    endfunction

    // Work out the result of one word and advance the shadow store
    function automatic t_glyph_rsp predict_lookup(input logic [7:0] b0, input logic [7:0] b1,
                                                  input logic [7:0] b2, input logic [2:0] n,
                                                  input logic fill);
        t_glyph_rsp       r;
        int               found;
        int               victim;
        int               oldest;
        logic [AGE_W-1:0] top_age;
        logic [31:0]      prod;
        r.cp     = utf8_to_cp(b0, b1, b2, n);
        r.status = STAT_REJECT;
        r.slot   = '0;
        r.offset = '0;
        if (cfg_enable && n != 3'd0 && {1'b0, r.cp} < cfg_glyphs) begin
            prod     = 32'(r.cp) * 32'(GLYPH_BYTES);
            r.offset = prod[OFFSET_W-1:0];
            found    = -1;
            for (int i = 0; i < CACHE_ENTRIES; i++)
                if (found < 0 && tag_valid[i] && tag_key[i] == r.cp)
                    found = i;
            if (found >= 0) begin
                tag_age[found] = '0;
                hit_cnt++;
                r.status = STAT_HIT;
                r.slot   = SLOT_W'(found);
            end else begin
                miss_cnt++;
                victim  = -1;
                oldest  = 0;
                top_age = '0;
                // stop looking for the oldest at the first free entry
                for (int i = 0; i < CACHE_ENTRIES; i++) begin
                    if (victim < 0) begin
                        if (!tag_valid[i]) begin
                            victim = i;
                        end else if (tag_age[i] > top_age) begin
                            top_age = tag_age[i];
                            oldest  = i;
                        end
                    end
                end
                if (victim < 0) begin
                    victim = oldest;
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                        if (tag_age[i] < AGE_MAX)
                            tag_age[i]++;
                end
                if (fill) begin
                    tag_valid[victim] = 1'b1;
                    tag_key[victim]   = r.cp;
                    tag_age[victim]   = '0;
                    r.status = STAT_MISS_FILL;
                end else begin
                    r.status = STAT_MISS_SKIP;
                end
                r.slot = SLOT_W'(victim);
            end
        end
        r.hits   = hit_cnt;
        r.misses = miss_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_glyph_rsp want;
        if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_rsp.size() == 0) begin
                err_count++;
                if (err_count <= SHOW_MAX)
                    $display("unexpected result word: st=%0d slot=%0d cp=%h",
                             rsp_bus.status, rsp_bus.slot, rsp_bus.codepoint);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_bus.status !== want.status || rsp_bus.slot !== want.slot ||
                    rsp_bus.codepoint !== want.cp || rsp_bus.read_offset !== want.offset ||
                    rsp_bus.hit_total !== want.hits || rsp_bus.miss_total !== want.misses) begin
                    err_count++;
                    if (err_count <= SHOW_MAX)
                        $display("mismatch exp st=%0d slot=%0d cp=%h off=%h hit=%0d miss=%0d",
                                 want.status, want.slot, want.cp, want.offset, want.hits,
                                 want.misses,
                                 " | got st=%0d slot=%0d cp=%h off=%h hit=%0d miss=%0d",
                                 rsp_bus.status, rsp_bus.slot,
                                 rsp_bus.codepoint, rsp_bus.read_offset,
                                 rsp_bus.hit_total, rsp_bus.miss_total);
                end
            end
        end
    end

    task automatic send_word(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                             input logic [2:0] n, input logic fill);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 32) begin
            req_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid      = 1'b1;
        req_bus.utf8_byte0 = b0;
        req_bus.utf8_byte1 = b1;
        req_bus.utf8_byte2 = b2;
        req_bus.byte_count = n;
        req_bus.fill_ok    = fill;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        pending_rsp.push_back(predict_lookup(b0, b1, b2, n, fill));
    endtask

    // Encode a codepoint in any UTF-8 form the decoder accepts for it
    task automatic send_cp(input logic [CP_W-1:0] cp, input logic fill);
        int         form;
        logic [7:0] b0, b1, b2;
        logic [2:0] n;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        if (cp < 16'h0100)
            form = $urandom_range(3, 1);
        else if (cp < 16'h0800)
            form = $urandom_range(3, 2);
        else
            form = 3;
        case (form)
            1: begin
                n  = 3'd1;
                b0 = cp[7:0];
            end
            2: begin
                n  = 3'd2;
                b0 = {3'b110, cp[10:6]};
                b1 = {2'b10, cp[5:0]};
            end
            default: begin
                n  = 3'd3;
                b0 = {4'b1110, cp[15:12]};
                b1 = {2'b10, cp[11:6]};
                b2 = {2'b10, cp[5:0]};
            end
        endcase
        send_word(b0, b1, b2, n, fill);
    endtask

    task automatic send_random_word(input int fill_pct);
        if ($urandom_range(99) < 15)
            send_word(8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom_range(7)),
                      1'($urandom));
        else
            send_cp(hot_cp[$urandom_range(hot_size - 1)], $urandom_range(99) < fill_pct);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Only called with nothing in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        cfg_we        = 1'b1;
        cfg_idx       = idx;
        cfg_wdata     = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == CFG_ENABLE)
            cfg_enable = val[0];
        else
            cfg_glyphs = val;
    endtask

    task automatic fill_hot_set(input int lo, input int hi, input int size);
        hot_size = size;
        for (int i = 0; i < size; i++)
            hot_cp[i] = CP_W'($urandom_range(hi, lo));
    endtask

    task automatic test_reset_reject();
        send_word(8'h41, 8'h00, 8'h00, 3'd1, 1'b1);
        send_word(8'hFF, 8'hFF, 8'hFF, 3'd0, 1'b1);
        wait_drain();
    endtask

    task automatic test_count_bounds();
        write_reg(CFG_ENABLE, 17'd1);
        write_reg(CFG_GLYPH_COUNT, 17'd0);
        send_word(8'h00, 8'h00, 8'h00, 3'd4, 1'b1);
        wait_drain();
        // codepoint zero becomes an ordinary key once it is allowed
        write_reg(CFG_GLYPH_COUNT, 17'd1);
        send_word(8'h00, 8'h00, 8'h00, 3'd4, 1'b1);
        send_word(8'h00, 8'h55, 8'hAA, 3'd1, 1'b0);
        send_word(8'hFF, 8'hFF, 8'hFF, 3'd7, 1'b0);
        wait_drain();
        write_reg(CFG_GLYPH_COUNT, 17'h00041);
        send_word(8'h41, 8'h00, 8'h00, 3'd1, 1'b1);
        send_word(8'h40, 8'h00, 8'h00, 3'd1, 1'b0);
        wait_drain();
    endtask

    task automatic test_decode_forms();
        write_reg(CFG_GLYPH_COUNT, 17'h10000);
        send_word(8'hFF, 8'h00, 8'h00, 3'd1, 1'b1);
        send_word(8'hC2, 8'h80, 8'h00, 3'd2, 1'b1);
        send_word(8'hDF, 8'hBF, 8'hFF, 3'd2, 1'b1);
        send_word(8'hE0, 8'h80, 8'h00, 3'd2, 1'b1);
        send_word(8'hC2, 8'hC0, 8'h00, 3'd2, 1'b1);
        send_word(8'hEF, 8'hBF, 8'hBF, 3'd3, 1'b1);
        send_word(8'hE0, 8'h80, 8'h80, 3'd3, 1'b1);
        send_word(8'hF0, 8'h80, 8'h80, 3'd3, 1'b1);
        send_word(8'hE1, 8'h80, 8'h00, 3'd3, 1'b1);
        send_word(8'hE1, 8'h80, 8'h81, 3'd3, 1'b0);
        send_word(8'hC3, 8'hA9, 8'h00, 3'd5, 1'b1);
        send_word(8'hEF, 8'hBF, 8'hBF, 3'd0, 1'b1);
        send_word(8'hEF, 8'hBF, 8'hBF, 3'd3, 1'b0);
        wait_drain();
    endtask

    task automatic test_enable_off();
        write_reg(CFG_ENABLE, 17'd0);
        send_word(8'hEF, 8'hBF, 8'hBF, 3'd3, 1'b1);
        send_word(8'h20, 8'h00, 8'h00, 3'd1, 1'b1);
        wait_drain();
        write_reg(CFG_ENABLE, 17'd1);
    endtask

    task automatic test_random_hot_set();
        write_reg(CFG_GLYPH_COUNT, 17'h10000);
        fill_hot_set(0, 65535, 20);
        repeat (500) send_random_word(70);
        wait_drain();
    endtask

    task automatic test_random_bounded_count();
        write_reg(CFG_GLYPH_COUNT, 17'($urandom_range(400, 1)));
        fill_hot_set(0, 511, 24);
        repeat (400) send_random_word(60);
        wait_drain();
    endtask

    task automatic test_random_no_gaps();
        write_reg(CFG_GLYPH_COUNT, 17'h1FFFF);
        fill_hot_set(0, 65535, 18);
        gaps_on = 1'b0;
        repeat (400) send_random_word(75);
        wait_drain();
        gaps_on = 1'b1;
    endtask

    // Refill the store, then miss mostly without installing so the ages climb towards the top
    task automatic test_age_saturation();
        write_reg(CFG_GLYPH_COUNT, 17'h0FFFF);
        repeat (16) send_cp(CP_W'($urandom_range(65534)), 1'b1);
        repeat (284) send_cp(CP_W'($urandom_range(65534)), $urandom_range(99) < 5);
        wait_drain();
    endtask

    task automatic test_random_mixed();
        write_reg(CFG_GLYPH_COUNT, 17'h10000);
        fill_hot_set(0, 2047, 17);
        repeat (150) send_random_word(50);
        wait_drain();
    endtask

    initial begin
        req_bus.valid      = 1'b0;
        req_bus.utf8_byte0 = '0;
        req_bus.utf8_byte1 = '0;
        req_bus.utf8_byte2 = '0;
        req_bus.byte_count = '0;
        req_bus.fill_ok    = 1'b0;
        gaps_on            = 1'b1;
        hit_cnt            = '0;
        miss_cnt           = '0;
        cfg_enable         = 1'b0;
        cfg_glyphs         = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            tag_valid[i] = 1'b0;
            tag_key[i]   = '0;
            tag_age[i]   = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_reject();
        test_count_bounds();
        test_decode_forms();
        test_enable_off();
        test_random_hot_set();
        test_random_bounded_count();
        test_random_no_gaps();
        test_age_saturation();
        test_random_mixed();

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && pending_rsp.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== glyph_cache_age_replacement_core.f =====
hdl/gcar_pkg.sv
hdl/gcar_req_if.sv
hdl/gcar_rsp_if.sv
hdl/gcar_ctrl.sv
hdl/gcar_datapath.sv
hdl/glyph_cache_age_replacement_core.sv
tb/tb_top.sv
